/* hw/rtl/cbp_pkg.sv */
// Shared types and constants for the configurable branch predictor.
`timescale 1ns / 1ps

package cbp_pkg;

    // Predictor modes
    typedef enum logic [1:0] {
        MODE_BIMODAL   = 2'd0,
        MODE_TWO_LEVEL = 2'd1,
        MODE_LOCAL     = 2'd2,
        MODE_GSHARE    = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_BITS = 3'd3;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] index_bits;
        logic [2:0] hist_len;
        logic [2:0] ctr_width;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:       MODE_BIMODAL,
        index_bits: 4'd8,
        hist_len:   3'd6,
        ctr_width:  3'd2
    };

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE
    } t_state;

    // Stream word layout
    localparam int ADDR_W     = 64;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

endpackage

/* hw/rtl/cbp_index.sv */
// Counter table index and local history address generation.
`timescale 1ns / 1ps

module cbp_index #(
    parameter int MAX_INDEX_BITS   = 8,
    parameter int MAX_HISTORY_BITS = 6
) (
    input  cbp_pkg::t_cfg                                    i_cfg,
    input  logic [cbp_pkg::ADDR_W-1:0]                       i_pc,
    input  logic [MAX_INDEX_BITS-1:0]                        i_gh,
    input  logic [MAX_HISTORY_BITS-1:0]                      i_lh,
    output logic [MAX_INDEX_BITS-1:0]                        o_lh_addr,
    output logic [MAX_INDEX_BITS+MAX_HISTORY_BITS-1:0]       o_ct_idx
);

    localparam int CT_AW = MAX_INDEX_BITS + MAX_HISTORY_BITS;

    logic [MAX_INDEX_BITS-1:0]   imask;
    logic [MAX_HISTORY_BITS-1:0] hmask;
    logic [MAX_INDEX_BITS-1:0]   addr_low;
    logic [MAX_HISTORY_BITS-1:0] hl;
    int                          hb_eff;

    always_comb begin
        for (int k = 0; k < MAX_INDEX_BITS; k++) begin
            imask[k] = int'(i_cfg.index_bits) > k;
        end
        for (int k = 0; k < MAX_HISTORY_BITS; k++) begin
            hmask[k] = int'(i_cfg.hist_len) > k;
        end
        // history length saturates at the stored width
        hb_eff = (int'(i_cfg.hist_len) > MAX_HISTORY_BITS) ?
                 MAX_HISTORY_BITS : int'(i_cfg.hist_len);
    end

    assign addr_low  = i_pc[MAX_INDEX_BITS-1:0] & imask;
    assign hl        = i_lh & hmask;
    assign o_lh_addr = addr_low;

    always_comb begin
        case (i_cfg.mode)
            cbp_pkg::MODE_BIMODAL:   o_ct_idx = CT_AW'(addr_low);
            cbp_pkg::MODE_TWO_LEVEL: o_ct_idx = CT_AW'(hl);
            cbp_pkg::MODE_LOCAL:     o_ct_idx = (CT_AW'(addr_low) << hb_eff) | CT_AW'(hl);
            cbp_pkg::MODE_GSHARE:    o_ct_idx = CT_AW'((i_pc[MAX_INDEX_BITS-1:0] ^ i_gh) & imask);
            default:                 o_ct_idx = CT_AW'(addr_low);
        endcase
    end

endmodule

/* hw/rtl/configurable_branch_predictor_unit.sv */
// Top level of the configurable branch direction predictor.
`timescale 1ns / 1ps

// Branch direction predictor with bimodal, two-level, local history and gshare
// modes. Each input word is a predict or an update request and yields exactly
// one result word carrying the prediction from the counter as read before any
// update. The local history memory is read in the accept cycle, its data forms
// the counter table index for a second read in the lookup state, and the
// counter is resolved and written back in the resolve state, which waits while
// the previous result is still held. A new word is accepted only once the last
// one has resolved, as the two synchronous memory reads depend on each other.
// After reset, and after every write to a defined configuration register, a
// clearing pass over every counter table address sets every counter to weakly
// taken and zeroes the local histories; no word is accepted during the pass.
// Configuration must only be written while the block is idle.
module configurable_branch_predictor_unit #(
    parameter int MAX_INDEX_BITS   = 8,
    parameter int MAX_HISTORY_BITS = 6,
    parameter int MAX_COUNTER_BITS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [63:0] branch_address, [64] actual_taken, [71:65] zero
    input  logic [cbp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: [0] kind (0 predict, 1 update)
    input  logic [0:0]                         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: [0] predict_taken, [7:1] zero
    output logic [cbp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CT_AW    = MAX_INDEX_BITS + MAX_HISTORY_BITS;
    localparam int CT_DEPTH = 1 << CT_AW;
    localparam int LH_DEPTH = 1 << MAX_INDEX_BITS;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    cbp_pkg::t_state                 r_state, n_state;
    cbp_pkg::t_cfg                   r_cfg;
    logic [CT_AW-1:0]                r_clr_cnt;
    logic [MAX_INDEX_BITS-1:0]       r_gh;
    logic [cbp_pkg::ADDR_W-1:0]      r_pc;
    logic                            r_kind;
    logic                            r_actual;
    logic [MAX_HISTORY_BITS-1:0]     r_lh_q;
    logic [MAX_COUNTER_BITS-1:0]     r_ct_q;
    logic                            r_out_valid;
    logic                            r_out_taken;

    // memories
    logic [MAX_COUNTER_BITS-1:0]     r_ct_mem [CT_DEPTH];
    logic [MAX_HISTORY_BITS-1:0]     r_lh_mem [LH_DEPTH];

    // ------------------------------------------------------------------
    // Handshake and config decode
    // ------------------------------------------------------------------
    logic cfg_hit;
    logic in_acc;
    logic step_done;

    // writes beyond the register list are dropped and do not clear tables
    assign cfg_hit       = i_cfg_we && (i_cfg_index <= cbp_pkg::REG_COUNTER_BITS);
    assign s_axis_tready = (r_state == cbp_pkg::S_IDLE) && !i_cfg_we;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Index generation: fed from the input word in the accept cycle so the
    // local history read can start right away, from the held word afterwards
    // ------------------------------------------------------------------
    logic [cbp_pkg::ADDR_W-1:0]  idx_pc;
    logic [MAX_INDEX_BITS-1:0]   lh_addr;
    logic [CT_AW-1:0]            ct_idx;

    assign idx_pc = (r_state == cbp_pkg::S_IDLE) ? s_axis_tdata[cbp_pkg::ADDR_W-1:0] : r_pc;

    cbp_index #(
        .MAX_INDEX_BITS   (MAX_INDEX_BITS),
        .MAX_HISTORY_BITS (MAX_HISTORY_BITS)
    ) u_index (
        .i_cfg     (r_cfg),
        .i_pc      (idx_pc),
        .i_gh      (r_gh),
        .i_lh      (r_lh_q),
        .o_lh_addr (lh_addr),
        .o_ct_idx  (ct_idx)
    );

    // ------------------------------------------------------------------
    // Counter arithmetic
    // ------------------------------------------------------------------
    int                          cb_eff;
    logic [MAX_COUNTER_BITS-1:0] weak_val;
    logic [MAX_COUNTER_BITS-1:0] cmax;
    logic [MAX_COUNTER_BITS-1:0] ctr_next;
    logic                        ctr_taken;

    always_comb begin
        // counter width saturates into 1..MAX_COUNTER_BITS
        if (r_cfg.ctr_width == 3'd0) begin
            cb_eff = 1;
        end else if (int'(r_cfg.ctr_width) > MAX_COUNTER_BITS) begin
            cb_eff = MAX_COUNTER_BITS;
        end else begin
            cb_eff = int'(r_cfg.ctr_width);
        end
        for (int k = 0; k < MAX_COUNTER_BITS; k++) begin
            cmax[k]     = k < cb_eff;
            weak_val[k] = k == (cb_eff - 1);
        end
    end

    assign ctr_taken = r_ct_q >= weak_val;

    always_comb begin
        ctr_next = r_ct_q;
        if (r_actual) begin
            if (r_ct_q < cmax) ctr_next = r_ct_q + 1'b1;
        end else begin
            if (r_ct_q != '0) ctr_next = r_ct_q - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                        ct_rd_en;
    logic                        ct_we;
    logic [CT_AW-1:0]            ct_waddr;
    logic [MAX_COUNTER_BITS-1:0] ct_wdata;
    logic                        lh_we;
    logic [MAX_INDEX_BITS-1:0]   lh_waddr;
    logic [MAX_HISTORY_BITS-1:0] lh_wdata;
    logic                        local_mode;

    assign local_mode = (r_cfg.mode == cbp_pkg::MODE_TWO_LEVEL) ||
                        (r_cfg.mode == cbp_pkg::MODE_LOCAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ct_rd_en  = 1'b0;
        ct_we     = 1'b0;
        ct_waddr  = ct_idx;
        ct_wdata  = ctr_next;
        lh_we     = 1'b0;
        lh_waddr  = lh_addr;
        // shift the outcome in, oldest bit drops off the top
        lh_wdata  = MAX_HISTORY_BITS'({r_lh_q, r_actual});
        step_done = 1'b0;
        case (r_state)
            cbp_pkg::S_CLEAR: begin
                // sweep: weak counters, zero histories (history index wraps)
                ct_we    = 1'b1;
                ct_waddr = r_clr_cnt;
                ct_wdata = weak_val;
                lh_we    = 1'b1;
                lh_waddr = r_clr_cnt[MAX_INDEX_BITS-1:0];
                lh_wdata = '0;
                if (r_clr_cnt == '1) n_state = cbp_pkg::S_IDLE;
            end
            cbp_pkg::S_IDLE: begin
                if (in_acc) n_state = cbp_pkg::S_LOOKUP;
            end
            cbp_pkg::S_LOOKUP: begin
                ct_rd_en = 1'b1;
                n_state  = cbp_pkg::S_RESOLVE;
            end
            cbp_pkg::S_RESOLVE: begin
                // wait here while the previous result is still held
                if (!r_out_valid || m_axis_tready) begin
                    step_done = 1'b1;
                    ct_we     = r_kind;
                    lh_we     = r_kind && local_mode;
                    n_state   = cbp_pkg::S_IDLE;
                end
            end
            default: n_state = cbp_pkg::S_CLEAR;
        endcase
        if (cfg_hit) n_state = cbp_pkg::S_CLEAR;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= cbp_pkg::CFG_RESET;
            r_clr_cnt   <= '0;
            r_gh        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cbp_pkg::REG_MODE:         r_cfg.mode <= cbp_pkg::t_mode'(i_cfg_wdata[1:0]);
                    cbp_pkg::REG_INDEX_BITS:   r_cfg.index_bits <= i_cfg_wdata[3:0];
                    cbp_pkg::REG_HISTORY_BITS: r_cfg.hist_len   <= i_cfg_wdata[2:0];
                    cbp_pkg::REG_COUNTER_BITS: r_cfg.ctr_width  <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end

            if (cfg_hit) begin
                r_clr_cnt <= '0;
            end else if (r_state == cbp_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end

            if (cfg_hit) begin
                r_gh <= '0;
            end else if (step_done && r_kind) begin
                r_gh <= MAX_INDEX_BITS'({r_gh, r_actual});
            end

            if (step_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pc     <= s_axis_tdata[cbp_pkg::ADDR_W-1:0];
            r_actual <= s_axis_tdata[cbp_pkg::ADDR_W];
            r_kind   <= s_axis_tuser[0];
        end
        if (step_done) begin
            r_out_taken <= ctr_taken;
        end
    end

    // local history memory: read at accept, written on resolve or clear
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lh_q <= r_lh_mem[lh_addr];
        end
        if (lh_we) begin
            r_lh_mem[lh_waddr] <= lh_wdata;
        end
    end

    // counter table: read in lookup, written on resolve or clear
    always_ff @(posedge i_clk) begin
        if (ct_rd_en) begin
            r_ct_q <= r_ct_mem[ct_idx];
        end
        if (ct_we) begin
            r_ct_mem[ct_waddr] <= ct_wdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(cbp_pkg::OUT_DATA_W-1){1'b0}}, r_out_taken};

endmodule

/* dv/configurable_branch_predictor_unit_test.sv */
// Self-checking testbench for the configurable branch predictor unit.
`timescale 1ns / 1ps

// Stimulus runs in phases. Phase 0 uses the reset settings and starts with a
// directed table. Each later phase rewrites some registers (idle block only)
// and sends random predict/update words. A local copy of the counter table,
// the per-address histories and the global history predicts each untyped result
// word. Both stream sides idle at random. The receiver stalls for a long stretch
// once, so the block backs up. The sender drains fully once in mid-phase.
module configurable_branch_predictor_unit_test;
    import cbp_pkg::*;

    localparam int MAX_IB = 8;
    localparam int MAX_HB = 6;
    localparam int MAX_CB = 4;
    localparam int DIR_DEPTH = 1 << (MAX_IB + MAX_HB);
    localparam int HIST_DEPTH = 1 << MAX_IB;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    // indexes past the defined registers: written once, must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd6;

    localparam int DRAIN_CYCLES   = 8;       // accept, lookup and resolve steps, keep margin
    localparam int LONG_HOLD      = 300;     // receiver back-pressure stretch
    localparam int WATCHDOG_LIMIT = 100000;  // outlasts the quiet clearing pass
    localparam int NUM_PHASES     = 8;
    localparam int PHASE0_ITEMS   = 120;
    localparam int PHASE_ITEMS    = 110;
    localparam int MAX_REPORTS    = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    configurable_branch_predictor_unit #(
        .MAX_INDEX_BITS   (MAX_IB),
        .MAX_HISTORY_BITS (MAX_HB),
        .MAX_COUNTER_BITS (MAX_CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the settings and the tables
    // ------------------------------------------------------------------
    logic [1:0]        cur_mode;
    logic [3:0]        cur_ib;
    logic [2:0]        cur_hb;
    logic [2:0]        cur_cb;
    logic [MAX_CB-1:0] dir_counters [DIR_DEPTH];
    logic [MAX_HB-1:0] branch_hist [HIST_DEPTH];
    logic [MAX_IB-1:0] path_hist;

    logic expected_dirs [$];   // predicted direction of each word in flight
    int   mismatches;
    int   quiet_cycles;
    bit   no_idle;             // both sides run without gaps while set
    bit   hold_req;            // sender asks the receiver for one long stall

    // counter width clamped into 1..MAX_CB; 0 behaves as 1
    function automatic int unsigned eff_ctr_width();
        if (cur_cb < 1) return 1;
        if (cur_cb > MAX_CB) return MAX_CB;
        return cur_cb;
    endfunction

    function automatic void clear_tables();
        logic [MAX_CB-1:0] weak_ctr;
        weak_ctr = MAX_CB'(1 << (eff_ctr_width() - 1));
        foreach (dir_counters[i]) dir_counters[i] = weak_ctr;
        foreach (branch_hist[i]) branch_hist[i] = '0;
        path_hist = '0;
    endfunction

    function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MODE:         cur_mode = val[1:0];
            REG_INDEX_BITS:   cur_ib   = val[3:0];
            REG_HISTORY_BITS: cur_hb   = val[2:0];
            REG_COUNTER_BITS: cur_cb   = val[2:0];
            default: return;   // undefined index: no effect, no re-init
        endcase
        clear_tables();
    endfunction

    // Returns the direction read before any training, then trains on updates.
    function automatic logic predict_and_train(logic kind, logic [63:0] pc,
                                               logic taken);
        int unsigned ib, hb, cb, cmax, weak_ctr, ctr;
        logic [63:0] imask, hmask, a, hl, idx;
        logic        dir;
        t_mode       mode;
        ib       = (cur_ib > MAX_IB) ? MAX_IB : cur_ib;
        hb       = (cur_hb > MAX_HB) ? MAX_HB : cur_hb;
        cb       = eff_ctr_width();
        cmax     = (1 << cb) - 1;
        weak_ctr = 1 << (cb - 1);
        imask    = (64'd1 << ib) - 64'd1;
        hmask    = (64'd1 << hb) - 64'd1;
        a        = pc & imask;
        hl       = 64'(branch_hist[a[MAX_IB-1:0]]) & hmask;
        mode     = t_mode'(cur_mode);
        case (mode)
            MODE_BIMODAL:   idx = a;
            MODE_TWO_LEVEL: idx = hl;
            MODE_LOCAL:     idx = (a << hb) | hl;
            default:        idx = (pc ^ 64'(path_hist)) & imask;
        endcase
        idx = idx & 64'(DIR_DEPTH - 1);
        ctr = dir_counters[idx[MAX_IB+MAX_HB-1:0]];
        dir = (ctr >= weak_ctr);
        if (kind == KIND_UPDATE) begin
            if (taken) begin
                if (ctr < cmax) ctr++;
            end else begin
                if (ctr > 0) ctr--;
            end
            dir_counters[idx[MAX_IB+MAX_HB-1:0]] = ctr[MAX_CB-1:0];
            path_hist = {path_hist[MAX_IB-2:0], taken};
            if (mode == MODE_TWO_LEVEL || mode == MODE_LOCAL)
                branch_hist[a[MAX_IB-1:0]] = {branch_hist[a[MAX_IB-1:0]][MAX_HB-2:0], taken};
        end
        return dir;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold, compares each result word
    // ------------------------------------------------------------------
    initial begin : result_sink
        int  stall_left;
        logic exp_dir;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (expected_dirs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result word 0x%02h", m_axis_tdata);
                end else begin
                    exp_dir = expected_dirs.pop_front();
                    if (m_axis_tdata !== {{(OUT_DATA_W-1){1'b0}}, exp_dir}) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("predict_taken mismatch: expected %0d, got word 0x%02h",
                                     exp_dir, m_axis_tdata);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold_req) begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any accepted word on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one request word and returns at the edge that accepts it.
    // A typed direction, where given, replaces the predicted one.
    task automatic send_request(logic kind, logic [63:0] pc, logic taken,
                                bit typed, logic typed_dir);
        int   gap;
        logic dir;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, taken, pc};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        dir = predict_and_train(kind, pc, taken);
        expected_dirs.push_back(typed ? typed_dir : dir);
    endtask

    task automatic wait_drained();
        while (expected_dirs.size() != 0) @(posedge i_clk);
    endtask

    // Register write on an idle block, then wait out any clearing pass.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_reg_write(idx, val);
        @(posedge i_clk);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    typedef struct packed {
        logic [3:0]            phase;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
    } reg_write_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] pc;
        logic        taken;
        logic        typed;   // direction below is checked as written
        logic        dir;
    } branch_row_t;

    reg_write_t  reg_plan [24];
    branch_row_t directed [18];

    // Random branch traffic. Most words reuse a small set of branch addresses
    // with a per-branch bias so that counters saturate and histories fill up.
    // The rest are random addresses and coin-flip outcomes.
    task automatic run_random(int n_items, int phase);
        logic [63:0] pool [8];
        logic        bias [8];
        logic [63:0] pc;
        logic        kind, taken;
        int          k;
        for (int i = 0; i < 8; i++) begin
            pool[i] = {$urandom, $urandom};
            bias[i] = $urandom_range(0, 1);
        end
        for (int n = 0; n < n_items; n++) begin
            no_idle = ((n / 40) % 3) == 1;
            if (phase == 2 && n == 20) hold_req = 1'b1;
            if (phase == 3 && n == 50) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            kind = $urandom_range(0, 1);
            if ($urandom_range(0, 99) < 85) begin
                k     = $urandom_range(0, 7);
                pc    = pool[k];
                taken = ($urandom_range(0, 99) < 80) ? bias[k] : ~bias[k];
            end else begin
                pc    = {$urandom, $urandom};
                taken = $urandom_range(0, 1);
            end
            send_request(kind, pc, taken, 1'b0, 1'b0);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        mismatches   = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_MODE;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_PREDICT;

        // reset settings: bimodal, 8 index bits, 6 history bits, 2-bit counters
        cur_mode = MODE_BIMODAL;
        cur_ib   = 4'd8;
        cur_hb   = 3'd6;
        cur_cb   = 3'd2;
        clear_tables();

        // settings sweep: every mode, width extremes, out-of-range widths,
        // counter width 0, and writes to undefined indexes
        reg_plan = '{
            '{4'd1, REG_MODE,         4'd3},
            '{4'd2, REG_MODE,         4'd1},
            '{4'd2, REG_HISTORY_BITS, 4'd3},
            '{4'd3, REG_MODE,         4'd2},
            '{4'd3, REG_INDEX_BITS,   4'd4},
            '{4'd3, REG_COUNTER_BITS, 4'd4},
            '{4'd4, REG_MODE,         4'hE},
            '{4'd4, REG_INDEX_BITS,   4'hF},
            '{4'd4, REG_HISTORY_BITS, 4'h7},
            '{4'd4, REG_COUNTER_BITS, 4'h7},
            '{4'd5, REG_MODE,         4'd3},
            '{4'd5, REG_INDEX_BITS,   4'd0},
            '{4'd5, REG_HISTORY_BITS, 4'd0},
            '{4'd5, REG_COUNTER_BITS, 4'd0},
            '{4'd6, REG_MODE,         4'd1},
            '{4'd6, REG_INDEX_BITS,   4'd2},
            '{4'd6, REG_HISTORY_BITS, 4'd6},
            '{4'd6, REG_COUNTER_BITS, 4'd1},
            '{4'd6, REG_SPARE_LO,     4'hA},
            '{4'd7, REG_MODE,         4'd0},
            '{4'd7, REG_INDEX_BITS,   4'd8},
            '{4'd7, REG_HISTORY_BITS, 4'd5},
            '{4'd7, REG_COUNTER_BITS, 4'd3},
            '{4'd7, REG_SPARE_HI,     4'h5}
        };

        // directed rows on the reset settings; counters start weakly taken
        directed = '{
            '{KIND_PREDICT, 64'h0,                 1'b0, 1'b1, 1'b1},
            '{KIND_PREDICT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1},
            '{KIND_UPDATE,  64'h12,                1'b0, 1'b1, 1'b1},
            '{KIND_PREDICT, 64'h12,                1'b0, 1'b1, 1'b0},
            '{KIND_UPDATE,  64'h12,                1'b0, 1'b1, 1'b0},
            '{KIND_UPDATE,  64'h12,                1'b0, 1'b1, 1'b0},
            '{KIND_PREDICT, 64'h112,               1'b1, 1'b1, 1'b0},  // aliases 0x12
            '{KIND_UPDATE,  64'h34,                1'b1, 1'b1, 1'b1},
            '{KIND_UPDATE,  64'h34,                1'b1, 1'b1, 1'b1},  // saturates high
            '{KIND_UPDATE,  64'h34,                1'b0, 1'b1, 1'b1},
            '{KIND_UPDATE,  64'h34,                1'b0, 1'b1, 1'b1},
            '{KIND_PREDICT, 64'h34,                1'b0, 1'b1, 1'b0},
            '{KIND_UPDATE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0},
            '{KIND_UPDATE,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0},
            '{KIND_UPDATE,  64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0},
            '{KIND_PREDICT, 64'h8000_0000_0000_00FF, 1'b1, 1'b0, 1'b0},
            '{KIND_PREDICT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0},
            '{KIND_PREDICT, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its tables after reset before taking any word
        do @(posedge i_clk); while (!s_axis_tready);

        foreach (directed[r])
            send_request(directed[r].kind, directed[r].pc, directed[r].taken,
                         directed[r].typed, directed[r].dir);
        run_random(PHASE0_ITEMS, 0);

        for (int p = 1; p < NUM_PHASES; p++) begin
            foreach (reg_plan[w])
                if (reg_plan[w].phase == p)
                    write_reg(reg_plan[w].idx, reg_plan[w].val);
            run_random(PHASE_ITEMS, p);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
